@@ rtl/core/smmh_pkg.sv @@
package smmh_pkg;

	localparam int KeyW   = 32;
	localparam int CountW = 10;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELMIN = 2'd1,
		OP_DELMAX = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// Keys are held with the sign bit flipped so that unsigned order is signed order.
	localparam logic [KeyW-1:0] SignFlip = {1'b1, {(KeyW-1){1'b0}}};

	typedef struct packed {
		logic [1:0]             op;
		logic signed [KeyW-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]             status;
		logic signed [KeyW-1:0] removed;
		logic [CountW-1:0]      count;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_INS_SIB,
		S_INS_UP,
		S_INS_L,
		S_INS_R,
		S_DEL_B,
		S_DEL_C,
		S_SIB_RD,
		S_SIB_CMP,
		S_CH1,
		S_CH2,
		S_CHDEC,
		S_RESP
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_FULL,
		DP_EMPTY,
		DP_INS_START,
		DP_INS_SIB,
		DP_INS_UP,
		DP_INS_L,
		DP_INS_R,
		DP_DEL_A,
		DP_DEL_B,
		DP_DEL_C,
		DP_SIB_RD,
		DP_SIB_CMP,
		DP_CH1,
		DP_CH2
	} dp_op_t;

	// The decision step of the sift-down shares the CH2 code space via a flag.
	typedef struct packed {
		dp_op_t op;
		logic   dec;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       empty;
		logic       ins_even;
		logic       cond;
	} dp_stat_t;

endpackage

@@ rtl/core/smmh_ctrl.sv @@
module smmh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  smmh_pkg::dp_stat_t stat,
	output smmh_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import smmh_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = DP_NOP;
		cmd.dec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = DP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							cmd.op  = DP_FULL;
							state_d = S_RESP;
						end else begin
							cmd.op  = DP_INS_START;
							state_d = stat.ins_even ? S_INS_SIB : S_INS_UP;
						end
					end
					OP_DELMIN, OP_DELMAX: begin
						if (stat.empty) begin
							cmd.op  = DP_EMPTY;
							state_d = S_RESP;
						end else begin
							cmd.op  = DP_DEL_A;
							state_d = S_DEL_B;
						end
					end
					default: state_d = S_RESP;
				endcase
			end
			S_INS_SIB: begin
				cmd.op  = DP_INS_SIB;
				state_d = S_INS_UP;
			end
			S_INS_UP: begin
				cmd.op  = DP_INS_UP;
				state_d = stat.cond ? S_RESP : S_INS_L;
			end
			S_INS_L: begin
				cmd.op  = DP_INS_L;
				state_d = stat.cond ? S_INS_UP : S_INS_R;
			end
			S_INS_R: begin
				cmd.op  = DP_INS_R;
				state_d = stat.cond ? S_INS_UP : S_RESP;
			end
			S_DEL_B: begin
				cmd.op  = DP_DEL_B;
				state_d = S_DEL_C;
			end
			S_DEL_C: begin
				cmd.op  = DP_DEL_C;
				state_d = stat.cond ? S_RESP : S_SIB_RD;
			end
			S_SIB_RD: begin
				cmd.op  = DP_SIB_RD;
				state_d = stat.cond ? S_SIB_CMP : S_CH1;
			end
			S_SIB_CMP: begin
				cmd.op  = DP_SIB_CMP;
				state_d = S_CH1;
			end
			S_CH1: begin
				cmd.op  = DP_CH1;
				state_d = stat.cond ? S_RESP : S_CH2;
			end
			S_CH2: begin
				cmd.op  = DP_CH2;
				state_d = S_CHDEC;
			end
			S_CHDEC: begin
				cmd.op  = DP_CH2;
				cmd.dec = 1'b1;
				state_d = stat.cond ? S_RESP : S_SIB_RD;
			end
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

@@ rtl/core/smmh_datapath.sv @@
module smmh_datapath #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smmh_pkg::cmd_t     in_cmd,
	input  smmh_pkg::dp_cmd_t  cmd,
	output smmh_pkg::dp_stat_t stat,
	output smmh_pkg::res_t     res
);
	import smmh_pkg::*;

	localparam int IW = $clog2(STORE_DEPTH);
	localparam int XW = IW + 2;

	logic [KeyW-1:0] mem [STORE_DEPTH];

	logic [1:0]      op_q;
	logic [1:0]      status_q;
	logic [KeyW-1:0] y_q, out_q, a_q, rdata_q;
	logic [IW-1:0]   e_q, c_q, n_q;

	logic            is_max;
	logic [XW-1:0]   e_x, n_x, sib_x, c1_x, c2_x;
	logic            sib_ok, c1_out, c2_ok, b2, stop, del_done;
	logic [IW-1:0]   par, gp, lc, rc, bi;
	logic [KeyW-1:0] bv;

	logic            rd_en, wr_en;
	logic [IW-1:0]   rd_addr, wr_addr;
	logic [KeyW-1:0] wr_data;

	assign is_max = (op_q == OP_DELMAX);
	assign e_x    = XW'(e_q);
	assign n_x    = XW'(n_q);
	assign sib_x  = is_max ? (e_x - XW'(1)) : (e_x + XW'(1));
	assign c1_x   = {e_x[XW-2:0], ~is_max};
	assign c2_x   = c1_x + XW'(2);
	assign sib_ok = is_max | (sib_x <= n_x);
	assign c1_out = (c1_x > n_x);
	assign c2_ok  = (c2_x <= n_x);

	assign par = (e_q - IW'(1)) >> 1;
	assign gp  = (par - IW'(1)) >> 1;
	assign lc  = {gp[IW-2:0], 1'b1};
	assign rc  = c_q + IW'(1);

	// Pick the better child: the smaller for delete-min, the larger for delete-max.
	assign b2   = c2_ok && (is_max ? (rdata_q > a_q) : (rdata_q < a_q));
	assign bv   = b2 ? rdata_q : a_q;
	assign bi   = b2 ? c2_x[IW-1:0] : c1_x[IW-1:0];
	assign stop = is_max ? (y_q >= bv) : (y_q <= bv);

	assign del_done = is_max ? (n_q < IW'(2)) : (n_q == '0);

	always_comb begin
		stat.op       = op_q;
		stat.full     = (n_q >= IW'(STORE_DEPTH - 1));
		stat.empty    = (n_q == '0);
		stat.ins_even = n_q[0];
		stat.cond     = 1'b0;
		case (cmd.op)
			DP_INS_UP:  stat.cond = (par == '0);
			DP_INS_L:   stat.cond = (y_q < rdata_q);
			DP_INS_R:   stat.cond = (y_q > rdata_q);
			DP_DEL_C:   stat.cond = del_done;
			DP_SIB_RD:  stat.cond = sib_ok;
			DP_CH1:     stat.cond = c1_out;
			DP_CH2:     stat.cond = cmd.dec & stop;
			default:    stat.cond = 1'b0;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = e_q;
		wr_data = y_q;
		case (cmd.op)
			DP_INS_START: begin
				rd_en   = 1'b1;
				rd_addr = n_q;
			end
			DP_INS_SIB: begin
				wr_en   = (y_q < rdata_q);
				wr_data = rdata_q;
			end
			DP_INS_UP: begin
				if (par == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = lc;
				end
			end
			DP_INS_L: begin
				if (y_q < rdata_q) begin
					wr_en   = 1'b1;
					wr_data = rdata_q;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rc;
				end
			end
			DP_INS_R: begin
				wr_en   = 1'b1;
				wr_data = (y_q > rdata_q) ? rdata_q : y_q;
			end
			DP_DEL_A: begin
				rd_en   = 1'b1;
				rd_addr = (!is_max || n_q == IW'(1)) ? IW'(1) : IW'(2);
			end
			DP_DEL_B: begin
				rd_en   = 1'b1;
				rd_addr = n_q;
			end
			DP_SIB_RD: begin
				rd_en   = sib_ok;
				rd_addr = sib_x[IW-1:0];
			end
			DP_SIB_CMP: begin
				wr_en   = is_max ? (y_q < rdata_q) : (y_q > rdata_q);
				wr_addr = sib_x[IW-1:0];
			end
			DP_CH1: begin
				if (c1_out) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = c1_x[IW-1:0];
				end
			end
			DP_CH2: begin
				if (cmd.dec) begin
					wr_en   = 1'b1;
					wr_data = stop ? y_q : bv;
				end else begin
					rd_en   = 1'b1;
					rd_addr = c2_x[IW-1:0];
				end
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			op_q     <= OP_INSERT;
			status_q <= ST_DONE;
		end else begin
			case (cmd.op)
				DP_LOAD: begin
					op_q     <= in_cmd.op;
					status_q <= ST_DONE;
				end
				DP_FULL:      status_q <= ST_FULL;
				DP_EMPTY:     status_q <= ST_EMPTY;
				DP_INS_START: n_q <= n_q + IW'(1);
				DP_DEL_B:     n_q <= n_q - IW'(1);
				default:      n_q <= n_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				y_q   <= in_cmd.value ^ SignFlip;
				out_q <= SignFlip;
			end
			DP_INS_START: e_q <= n_q + IW'(1);
			DP_INS_SIB: begin
				if (y_q < rdata_q) begin
					e_q <= e_q - IW'(1);
				end
			end
			DP_INS_UP: c_q <= lc;
			DP_INS_L: begin
				if (y_q < rdata_q) begin
					e_q <= c_q;
				end
			end
			DP_INS_R: begin
				if (y_q > rdata_q) begin
					e_q <= rc;
				end
			end
			DP_DEL_B: out_q <= rdata_q;
			DP_DEL_C: begin
				y_q <= rdata_q;
				e_q <= is_max ? IW'(2) : IW'(1);
			end
			DP_SIB_CMP: begin
				if (is_max ? (y_q < rdata_q) : (y_q > rdata_q)) begin
					y_q <= rdata_q;
				end
			end
			DP_CH2: begin
				if (cmd.dec) begin
					if (!stop) begin
						e_q <= bi;
					end
				end else begin
					a_q <= rdata_q;
				end
			end
			default: a_q <= a_q;
		endcase
	end

	assign res.status  = status_q;
	assign res.removed = out_q ^ SignFlip;
	assign res.count   = CountW'(n_q);

endmodule

@@ rtl/core/symmetric_min_max_heap_unit.sv @@
// Double-ended priority queue of signed 32-bit keys, kept as a symmetric min-max heap in
// a single-port-read, single-port-write memory of STORE_DEPTH words (slot 0 is unused, so
// at most STORE_DEPTH-1 keys are held). A command beat is taken when start is high while
// busy is low; busy then stays high until the result has been shown. The result appears
// for exactly one cycle with done high, and the receiver cannot stall it, so it must take
// every beat as it comes. An insert on a full heap or a delete on an empty one returns its
// status code and leaves the heap untouched; removed is zero except after a good delete.
// The time a command takes is set by the memory walk along one root-to-leaf path: each
// level costs one memory read per visited key with the data registered. A rejected
// command or the spare code goes straight to the result; an insert climbs the path level
// by level and a delete descends it. One command is in work at a time.
// No clearing pass is needed after reset: a value read from a slot that holds no key is never used.
module symmetric_min_max_heap_unit #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  smmh_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output smmh_pkg::res_t res
);
	import smmh_pkg::*;

	// The controller steps through the walk; the datapath holds the store, the
	// working key and the slot pointers, and reports the comparisons back.
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	smmh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	smmh_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.in_cmd (cmd),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.res    (res)
	);

endmodule

@@ bench/tb_top.sv @@
// Bench for the symmetric min-max heap unit.
// Command beats go in through start/busy. Each one is checked against a local model of the
// heap: an array of keys kept with the sign bit flipped, walked exactly as the block walks it.
// Result beats come one cycle each with done high, and the bench cannot stall them.
module tb_top;
	import smmh_pkg::*;

	localparam int Depth    = 1024;
	localparam int Cap      = Depth - 1;
	localparam int WdogMax  = 20000;
	localparam int NRandom  = 120;
	localparam int NDrain   = 40;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	res_t res;

	symmetric_min_max_heap_unit #(.STORE_DEPTH(Depth)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .res(res)
	);

	// Local copy of the heap. Keys are held with the sign bit flipped, so an unsigned
	// compare gives the signed order.
	logic [31:0] heap_keys [0:Depth-1];
	int unsigned heap_count;
	res_t        pending_results [$];
	int          mismatches;
	int          wdog;
	int          idle_pct;

	// Row of the directed table. If has_exp is set, the result is typed in by hand and
	// is also compared with the model.
	typedef struct {
		op_t         op;
		logic [31:0] value;
		bit          has_exp;
		status_t     exp_status;
		logic [31:0] exp_removed;
		int          exp_count;
	} dir_row_t;

	function automatic logic [31:0] hk(int unsigned i);
		return (i < Depth) ? heap_keys[i] : 32'd0;
	endfunction

	function automatic void heap_put(int unsigned i, logic [31:0] v);
		if (i < Depth) heap_keys[i] = v;
	endfunction

	function automatic void heap_insert(logic [31:0] y);
		int unsigned e, par, g, lc, rc;
		heap_count = heap_count + 1;
		e = heap_count;
		if ((e % 2) == 0 && y < hk(e - 1)) begin
			heap_put(e, hk(e - 1));
			e = e - 1;
		end
		forever begin
			par = (e - 1) >> 1;
			if (par == 0) break;
			g  = (par - 1) >> 1;
			lc = 2 * g + 1;
			rc = 2 * g + 2;
			if (y < hk(lc)) begin
				heap_put(e, hk(lc));
				e = lc;
			end else if (y > hk(rc)) begin
				heap_put(e, hk(rc));
				e = rc;
			end else begin
				break;
			end
		end
		heap_put(e, y);
	endfunction

	function automatic logic [31:0] heap_take_min();
		logic [31:0] taken, y, t;
		int unsigned n, e, c1, c2, best;
		taken = hk(1);
		n = heap_count;
		y = hk(n);
		e = 1;
		n = n - 1;
		heap_count = n;
		if (n == 0) return taken;
		forever begin
			if (e + 1 <= n && y > hk(e + 1)) begin
				t = hk(e + 1);
				heap_put(e + 1, y);
				y = t;
			end
			c1 = 2 * e + 1;
			c2 = 2 * e + 3;
			if (c1 > n) break;
			best = c1;
			if (c2 <= n && hk(c2) < hk(c1)) best = c2;
			if (y <= hk(best)) break;
			heap_put(e, hk(best));
			e = best;
		end
		heap_put(e, y);
		return taken;
	endfunction

	function automatic logic [31:0] heap_take_max();
		logic [31:0] taken, y, t;
		int unsigned n, e, c1, c2, best;
		n = heap_count;
		e = 2;
		if (n == 1) begin
			heap_count = 0;
			return hk(1);
		end
		taken = hk(2);
		y = hk(n);
		n = n - 1;
		heap_count = n;
		if (n < 2) return taken;
		forever begin
			if (y < hk(e - 1)) begin
				t = hk(e - 1);
				heap_put(e - 1, y);
				y = t;
			end
			c1 = 2 * e;
			c2 = 2 * e + 2;
			if (c1 > n) break;
			best = c1;
			if (c2 <= n && hk(c2) > hk(c1)) best = c2;
			if (y >= hk(best)) break;
			heap_put(e, hk(best));
			e = best;
		end
		heap_put(e, y);
		return taken;
	endfunction

	// Applies one command to the local heap and returns the result it should give.
	function automatic res_t heap_apply(op_t op, logic [31:0] value);
		res_t r;
		r.status  = ST_DONE;
		r.removed = '0;
		case (op)
			OP_INSERT: begin
				if (heap_count >= Cap) r.status = ST_FULL;
				else heap_insert(value ^ SignFlip);
			end
			OP_DELMIN, OP_DELMAX: begin
				if (heap_count == 0) r.status = ST_EMPTY;
				else if (op == OP_DELMIN) r.removed = heap_take_min() ^ SignFlip;
				else r.removed = heap_take_max() ^ SignFlip;
			end
			default: ;
		endcase
		r.count = heap_count[CountW-1:0];
		return r;
	endfunction

	function automatic void report_mismatch(string what, res_t want, res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"MISMATCH %s: expected status=%0d removed=%0d count=%0d,",
				" got status=%0d removed=%0d count=%0d"},
				what, want.status, want.removed, want.count,
				got.status, got.removed, got.count);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side. Each beat is compared with the oldest pending result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", '0, res);
			end else begin
				res_t want;
				want = pending_results.pop_front();
				if (want.status != res.status || want.removed != res.removed
						|| want.count != res.count)
					report_mismatch("result", want, res);
			end
		end
	end

	// Watchdog: ends the run when no beat moves either way for too long.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WdogMax) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offers one command and holds it until it is taken. The model is updated at the
	// accepting edge, before the result can come back. Start stays high after the
	// accepting edge; busy keeps the block from taking it again, and the next call or
	// a drain drops it.
	task automatic send_cmd(op_t op, logic [31:0] value, output res_t want);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd.op <= op;
		cmd.value <= value;
		do @(posedge clk); while (busy);
		want = heap_apply(op, value);
		pending_results.push_back(want);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Random op with an insert bias set by the caller, so the heap both fills and empties.
	task automatic random_cmd(int ins_pct);
		res_t want;
		op_t op;
		int r;
		logic [31:0] v;
		r = $urandom_range(99);
		if (r < ins_pct) op = OP_INSERT;
		else if (r < 98) op = ($urandom_range(1)) ? OP_DELMIN : OP_DELMAX;
		else op = OP_SPARE;
		case ($urandom_range(5))
			0: v = $urandom_range(7);
			1: v = 32'h8000_0000 + $urandom_range(3);
			2: v = 32'h7fff_ffff - $urandom_range(3);
			default: v = $urandom;
		endcase
		send_cmd(op, v, want);
	endtask

	dir_row_t dir_rows [$];

	initial begin
		res_t want;
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		heap_count = 0;
		mismatches = 0;
		wdog = 0;
		idle_pct = 0;
		for (i = 0; i < Depth; i++) heap_keys[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty deletes, extremes, ties, max with a single key, spare op.
		dir_rows = '{
			'{OP_DELMIN, 32'd0, 1, ST_EMPTY, 32'd0, 0},
			'{OP_DELMAX, 32'd0, 1, ST_EMPTY, 32'd0, 0},
			'{OP_SPARE, 32'hffff_ffff, 1, ST_DONE, 32'd0, 0},
			'{OP_INSERT, 32'h8000_0000, 1, ST_DONE, 32'd0, 1},
			'{OP_DELMAX, 32'd0, 1, ST_DONE, 32'h8000_0000, 0},
			'{OP_INSERT, 32'h7fff_ffff, 1, ST_DONE, 32'd0, 1},
			'{OP_INSERT, 32'h8000_0000, 1, ST_DONE, 32'd0, 2},
			'{OP_INSERT, 32'd5, 0, ST_DONE, 32'd0, 0},
			'{OP_INSERT, 32'd5, 0, ST_DONE, 32'd0, 0},
			'{OP_INSERT, 32'hffff_fffb, 0, ST_DONE, 32'd0, 0},
			'{OP_INSERT, 32'd5, 0, ST_DONE, 32'd0, 0},
			'{OP_INSERT, 32'd0, 0, ST_DONE, 32'd0, 0},
			'{OP_INSERT, 32'h7fff_ffff, 0, ST_DONE, 32'd0, 0},
			'{OP_DELMAX, 32'd0, 1, ST_DONE, 32'h7fff_ffff, 7},
			'{OP_DELMIN, 32'd0, 1, ST_DONE, 32'h8000_0000, 6},
			'{OP_DELMIN, 32'd0, 0, ST_DONE, 32'd0, 0},
			'{OP_DELMAX, 32'd0, 0, ST_DONE, 32'd0, 0},
			'{OP_DELMAX, 32'd0, 0, ST_DONE, 32'd0, 0},
			'{OP_DELMIN, 32'd0, 0, ST_DONE, 32'd0, 0},
			'{OP_DELMAX, 32'd0, 0, ST_DONE, 32'd0, 0},
			'{OP_DELMIN, 32'd0, 0, ST_DONE, 32'd0, 0},
			'{OP_DELMIN, 32'd0, 1, ST_EMPTY, 32'd0, 0}
		};
		foreach (dir_rows[k]) begin
			send_cmd(dir_rows[k].op, dir_rows[k].value, want);
			if (dir_rows[k].has_exp && (want.status != dir_rows[k].exp_status
					|| want.removed != dir_rows[k].exp_removed
					|| want.count != dir_rows[k].exp_count[CountW-1:0])) begin
				res_t typed;
				typed.status  = dir_rows[k].exp_status;
				typed.removed = dir_rows[k].exp_removed;
				typed.count   = dir_rows[k].exp_count[CountW-1:0];
				report_mismatch("table row", typed, want);
			end
		end
		wait_drained();

		// Random part in three idling phases; the heap swings up and down within each.
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 23 : ((ph == 1) ? 51 : 0);
			for (i = 0; i < NRandom / 3; i++)
				random_cmd(((i / 20) % 2 == 0) ? 70 : 30);
			wait_drained();
		end

		// Fill to capacity, overflow, then take keys off the full heap so the deletes
		// sift down the longest paths. Full is only reached here.
		idle_pct = 0;
		while (heap_count < Cap) random_cmd(100);
		send_cmd(OP_INSERT, 32'h7fff_ffff, want);
		send_cmd(OP_INSERT, 32'h8000_0000, want);
		for (i = 0; i < NDrain; i++)
			send_cmd(($urandom_range(1)) ? OP_DELMIN : OP_DELMAX, $urandom, want);

		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
